FILE: design/apa_pkg.sv
`timescale 1ns / 1ps

package apa_pkg;

    localparam int APA_POOL_MAX = 256;

    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int OFFSET_W  = 16;
    localparam int PREFIX_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_MIN   = 5'd16;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX   = 5'd30;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 5'd24;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 2'd1;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIN     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

    typedef logic [2:0] cmd_kind_t;

    localparam cmd_kind_t KIND_ALLOC   = 3'd0;
    localparam cmd_kind_t KIND_PIN     = 3'd1;
    localparam cmd_kind_t KIND_RELEASE = 3'd2;
    localparam cmd_kind_t KIND_REFUSE  = 3'd3;
    localparam cmd_kind_t KIND_OUTSIDE = 3'd4;

    localparam int KIND_W = $bits(cmd_kind_t);

    localparam logic [OFFSET_W-1:0] FIRST_CLIENT = 16'd2;
    localparam logic [OFFSET_W-1:0] SERVER_OFF   = 16'd1;

endpackage

FILE: design/apa_queue.sv
`timescale 1ns / 1ps

module apa_queue
    import apa_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         valid,
    output logic [W-1:0] head,
    input  logic         pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     entry_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/apa_front.sv
`timescale 1ns / 1ps

module apa_front
    import apa_pkg::*;
#(
    parameter int POOL_MAX = APA_POOL_MAX
)
(
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [REQ_W-1:0]                         s_tuser,
    input  logic [OFFSET_W+ADDR_W-1:0]               s_tdata,
    input  logic [$clog2(POOL_MAX+1)-1:0]            size,
    input  logic [ADDR_W-1:0]                        base_addr,
    input  logic                                     clearing,
    input  logic                                     q_full,
    output logic                                     q_push,
    output logic [KIND_W+$clog2(POOL_MAX+1)-1:0]     q_data
);

    localparam int OFF_W = $clog2(POOL_MAX + 1);

    logic [OFFSET_W-1:0] req_off;
    logic [ADDR_W-1:0]   req_addr;
    logic [ADDR_W-1:0]   rel_diff;
    logic                pin_ok;
    logic                rel_ok;
    cmd_kind_t           kind;
    logic [OFF_W-1:0]    cmd_off;

    assign req_off  = s_tdata[OFFSET_W-1:0];
    assign req_addr = s_tdata[OFFSET_W+ADDR_W-1:OFFSET_W];
    assign rel_diff = req_addr - base_addr;

    // pinned offset must lie in 2..size, release offset in 1..size
    assign pin_ok = (req_off >= FIRST_CLIENT) && (req_off <= OFFSET_W'(size));
    assign rel_ok = (req_addr >= base_addr) && (rel_diff != '0)
                    && (rel_diff <= ADDR_W'(size));

    always_comb
    begin
        kind    = KIND_REFUSE;
        cmd_off = '0;
        case (s_tuser)
            REQ_ALLOC:
            begin
                kind = KIND_ALLOC;
            end
            REQ_PIN:
            begin
                if (pin_ok)
                begin
                    kind    = KIND_PIN;
                    cmd_off = req_off[OFF_W-1:0];
                end
            end
            REQ_RELEASE:
            begin
                if (rel_ok)
                begin
                    kind    = KIND_RELEASE;
                    cmd_off = rel_diff[OFF_W-1:0];
                end
                else
                begin
                    kind = KIND_OUTSIDE;
                end
            end
            default:
            begin
                kind = KIND_REFUSE;
            end
        endcase
    end

    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = {kind, cmd_off};

endmodule

FILE: design/apa_back.sv
`timescale 1ns / 1ps

module apa_back
    import apa_pkg::*;
#(
    parameter int POOL_MAX = APA_POOL_MAX
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(POOL_MAX+1)-1:0]        size,
    input  logic [ADDR_W-1:0]                    base_addr,
    input  logic                                 q_valid,
    input  logic [KIND_W+$clog2(POOL_MAX+1)-1:0] q_data,
    output logic                                 q_pop,
    output logic                                 clearing,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [STATUS_W-1:0]                  m_tuser,
    output logic [ADDR_W-1:0]                    m_tdata
);

    localparam int OFF_W  = $clog2(POOL_MAX + 1);
    localparam int NXT_W  = $clog2(POOL_MAX + 2);
    localparam int MOD_CW = $clog2(NXT_W);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PIN   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    logic mem [0:POOL_MAX];

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [OFF_W-1:0]    clr_reg;
    logic [OFF_W-1:0]    clr_next;
    logic [NXT_W-1:0]    next_off_reg;
    logic [NXT_W-1:0]    next_off_next;
    logic [NXT_W-1:0]    mod_val_reg;
    logic [NXT_W-1:0]    mod_val_next;
    logic [MOD_CW-1:0]   mod_cnt_reg;
    logic [MOD_CW-1:0]   mod_cnt_next;
    logic [OFF_W-1:0]    mod_rem_reg;
    logic [OFF_W-1:0]    mod_rem_next;
    logic [OFF_W:0]      mod_shift;
    logic [OFF_W:0]      mod_trial;
    logic [OFF_W-1:0]    scan_off_reg;
    logic [OFF_W-1:0]    scan_off_next;
    logic [OFF_W-1:0]    issued_reg;
    logic [OFF_W-1:0]    issued_next;
    logic                chk_valid_reg;
    logic                chk_valid_next;
    logic                chk_last_reg;
    logic                chk_last_next;
    logic [OFF_W-1:0]    chk_off_reg;
    logic [OFF_W-1:0]    chk_off_next;
    logic [OFF_W-1:0]    cur_off_reg;
    logic [OFF_W-1:0]    cur_off_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [ADDR_W-1:0]   out_addr_next;
    logic                rd_data_reg;

    logic                mem_we;
    logic [OFF_W-1:0]    mem_waddr;
    logic                mem_wdata;
    logic [OFF_W-1:0]    mem_raddr;

    cmd_kind_t           q_kind;
    logic [OFF_W-1:0]    q_off;

    assign q_kind = q_data[KIND_W+OFF_W-1:OFF_W];
    assign q_off  = q_data[OFF_W-1:0];

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_addr_reg;

    // one restoring step of (next - 1) mod size
    assign mod_shift = {mod_rem_reg, mod_val_reg[mod_cnt_reg]};
    assign mod_trial = (mod_shift >= {1'b0, size}) ? mod_shift - {1'b0, size} : mod_shift;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        next_off_next   = next_off_reg;
        mod_val_next    = mod_val_reg;
        mod_cnt_next    = mod_cnt_reg;
        mod_rem_next    = mod_rem_reg;
        scan_off_next   = scan_off_reg;
        issued_next     = issued_reg;
        chk_valid_next  = 1'b0;
        chk_last_next   = 1'b0;
        chk_off_next    = chk_off_reg;
        cur_off_next    = cur_off_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = 1'b0;
        mem_raddr       = '0;
        q_pop           = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == OFF_W'(POOL_MAX))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + OFF_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    case (q_kind)
                        KIND_ALLOC:
                        begin
                            mod_val_next = next_off_reg - NXT_W'(1);
                            mod_cnt_next = MOD_CW'(NXT_W - 1);
                            mod_rem_next = '0;
                            state_next   = ST_MOD;
                        end
                        KIND_PIN:
                        begin
                            mem_raddr    = q_off;
                            cur_off_next = q_off;
                            state_next   = ST_PIN;
                        end
                        KIND_RELEASE:
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = q_off;
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_DONE;
                            out_addr_next   = '0;
                        end
                        KIND_OUTSIDE:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OUTSIDE;
                            out_addr_next   = '0;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_REFUSED;
                            out_addr_next   = '0;
                        end
                    endcase
                end
            end
            ST_PIN:
            begin
                out_valid_next = 1'b1;
                if (!rd_data_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = cur_off_reg;
                    mem_wdata       = 1'b1;
                    out_status_next = STATUS_DONE;
                    out_addr_next   = base_addr + ADDR_W'(cur_off_reg);
                end
                else
                begin
                    out_status_next = STATUS_REFUSED;
                    out_addr_next   = '0;
                end
                state_next = ST_IDLE;
            end
            ST_MOD:
            begin
                mod_rem_next = mod_trial[OFF_W-1:0];
                if (mod_cnt_reg == '0)
                begin
                    scan_off_next = mod_trial[OFF_W-1:0] + OFF_W'(1);
                    issued_next   = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    mod_cnt_next = mod_cnt_reg - MOD_CW'(1);
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && (chk_off_reg != OFF_W'(SERVER_OFF)) && !rd_data_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_off_reg;
                    mem_wdata       = 1'b1;
                    next_off_next   = NXT_W'(chk_off_reg) + NXT_W'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_DONE;
                    out_addr_next   = base_addr + ADDR_W'(chk_off_reg);
                    state_next      = ST_IDLE;
                end
                else if (chk_valid_reg && chk_last_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_REFUSED;
                    out_addr_next   = '0;
                    state_next      = ST_IDLE;
                end
                else if (issued_reg != size)
                begin
                    mem_raddr      = scan_off_reg;
                    chk_valid_next = 1'b1;
                    chk_off_next   = scan_off_reg;
                    chk_last_next  = (issued_reg == size - OFF_W'(1));
                    scan_off_next  = (scan_off_reg == size) ? OFF_W'(1)
                                                            : scan_off_reg + OFF_W'(1);
                    issued_next    = issued_reg + OFF_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            next_off_reg  <= NXT_W'(FIRST_CLIENT);
            mod_cnt_reg   <= '0;
            issued_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_off_reg  <= next_off_next;
            mod_cnt_reg   <= mod_cnt_next;
            issued_reg    <= issued_next;
            chk_valid_reg <= chk_valid_next;
            chk_last_reg  <= chk_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_val_reg    <= mod_val_next;
        mod_rem_reg    <= mod_rem_next;
        scan_off_reg   <= scan_off_next;
        chk_off_reg    <= chk_off_next;
        cur_off_reg    <= cur_off_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // used-bit map
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

FILE: design/address_pool_allocator.sv
`timescale 1ns / 1ps

// Hands out IPv4 host addresses from a subnet pool of min(2^(32-prefix)-2, POOL_MAX)
// offsets (prefix clamped to 16..30), offset 1 kept for the server. After reset the
// used-bit memory is swept clear, one entry a cycle, over all POOL_MAX+1 entries;
// no item is taken during that sweep, configuration writes are. Items pass a
// classifier and a two-entry queue into an executor that owns the used-bit memory,
// with one write and one read port. A release or a refused item is handled in the
// idle state; a pinned allocation reads the memory, then updates it if the offset
// is free. A next-fit allocation first reduces the pointer modulo the pool size bit
// by bit, then reads the memory once per probed offset until a free offset is found
// or all size offsets have been probed. The executor starts the next item once the
// output register is empty. Write configuration only while the block is idle.

module address_pool_allocator
    import apa_pkg::*;
#(
    parameter int POOL_MAX = APA_POOL_MAX
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ADDR_W-1:0]          cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [REQ_W-1:0]           s_tuser,   // req_type
    input  logic [OFFSET_W+ADDR_W-1:0] s_tdata,   // offset, address
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [STATUS_W-1:0]        m_tuser,   // status
    output logic [ADDR_W-1:0]          m_tdata    // assigned_addr
);

    localparam int OFF_W   = $clog2(POOL_MAX + 1);
    localparam int CMD_W   = KIND_W + OFF_W;
    localparam int TOTAL_W = OFFSET_W + 1;

    logic [ADDR_W-1:0]   base_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [PREFIX_W-1:0] prefix_clamped;
    logic [PREFIX_W-1:0] host_width;
    logic [TOTAL_W-1:0]  host_total;
    logic [OFF_W-1:0]    size;
    logic                clearing;
    logic                q_full;
    logic                q_push;
    logic [CMD_W-1:0]    q_in;
    logic                q_valid;
    logic [CMD_W-1:0]    q_head;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            prefix_reg <= PREFIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_ADDR:
                begin
                    base_reg <= cfg_data;
                end
                REG_PREFIX_LENGTH:
                begin
                    prefix_reg <= cfg_data[PREFIX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // pool size from the clamped prefix
    assign prefix_clamped = (prefix_reg < PREFIX_MIN) ? PREFIX_MIN :
                            (prefix_reg > PREFIX_MAX) ? PREFIX_MAX : prefix_reg;
    assign host_width = PREFIX_W'(ADDR_W) - prefix_clamped;
    assign host_total = (TOTAL_W'(1) << host_width) - TOTAL_W'(2);
    assign size       = (host_total > TOTAL_W'(POOL_MAX)) ? OFF_W'(POOL_MAX)
                                                          : host_total[OFF_W-1:0];

    apa_front #(
        .POOL_MAX (POOL_MAX)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .size      (size),
        .base_addr (base_reg),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    apa_queue #(
        .W (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    apa_back #(
        .POOL_MAX (POOL_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size),
        .base_addr (base_reg),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // only a successful allocation carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_DONE) |-> (m_tdata == '0))
        else $error("non-zero address on a failed result");

    // no item taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready)
        else $error("item accepted while clearing");

    // an accepted item is queued for the executor
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> q_valid)
        else $error("accepted item lost before the queue");

endmodule
